@@ rtl/cgi_pkg.sv @@
// Package for the cylindrical grid interpolator.
// Holds the shared widths, defaults and saturation constants; no dependencies.
package cgi_pkg;

	localparam int CELL_COUNT_DEF = 1024;
	localparam int DATA_W = 32;
	localparam int INDEX_W = 10;
	localparam int ROOT_W = 32;
	localparam int DIFF_W = DATA_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int MAG_W = 35;
	localparam int SUM_W = MAG_W + 1;
	localparam logic [MAG_W-1:0] SAT_LIMIT = MAG_W'(1) << 34;

endpackage

@@ rtl/cylindrical_grid_interpolator_core.sv @@
// Cylindrical grid interpolator: a query runs from acceptance to its result
// word through two sequential passes over the cell tables, a square root
// and up to three divide steps, one per interpolation with a nonzero span.
// A load is accepted one per cycle; one query at a time, the block is not ready meanwhile.
// Reset is asynchronous, active low; it clears control state, the tables stay undefined.
// Depends on cgi_pkg, cgi_ram, cgi_sqrt and cgi_div.
module cylindrical_grid_interpolator_core #(
	parameter int CELL_COUNT = cgi_pkg::CELL_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [cgi_pkg::INDEX_W-1:0]       cell_index,
	input  logic [cgi_pkg::DATA_W-1:0]        cell_radius,
	input  logic [cgi_pkg::DATA_W-1:0]        cell_altitude,
	input  logic signed [cgi_pkg::DATA_W-1:0] cell_value,
	input  logic signed [cgi_pkg::DATA_W-1:0] x_pos,
	input  logic signed [cgi_pkg::DATA_W-1:0] y_pos,
	input  logic signed [cgi_pkg::DATA_W-1:0] z_pos,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cgi_pkg::DATA_W-1:0] interp_value,
	output logic                              found
);

	localparam int AW = $clog2(CELL_COUNT);
	localparam int DW = cgi_pkg::DATA_W;
	localparam int FW = cgi_pkg::DIFF_W;
	localparam int PW = cgi_pkg::PROD_W;
	localparam int MW = cgi_pkg::MAG_W;
	localparam int SW = cgi_pkg::SUM_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(CELL_COUNT - 2);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_SQX   = 12'b0000_0000_0010,
		ST_SQY   = 12'b0000_0000_0100,
		ST_SQS   = 12'b0000_0000_1000,
		ST_SQRT  = 12'b0000_0001_0000,
		ST_RSCAN = 12'b0000_0010_0000,
		ST_VSCAN = 12'b0000_0100_0000,
		ST_FETCH = 12'b0000_1000_0000,
		ST_LSET  = 12'b0001_0000_0000,
		ST_LMUL  = 12'b0010_0000_0000,
		ST_LDIV  = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [DW-1:0]        mx_q, my_q, alt_q, rad_q;
	logic [2*DW-1:0]      sum_q;
	logic [PW-1:0]        mul_p_q;
	logic [FW-1:0]        mul_a, mul_b;
	logic [AW-1:0]        rd_addr_q, rd_idx_s1;
	logic                 issue_q, rd_vld_s1;
	logic [DW-1:0]        prev_rad_q, prev_alt_q, rlo_q, rhi_q;
	logic                 fa_q, fb_q;
	logic [AW-1:0]        za_q, zb_q;
	logic [2:0]           fcnt_q;
	logic [DW-1:0]        f_alt_q [4];
	logic [DW-1:0]        f_val_q [4];
	logic [1:0]           lsel_q;
	logic [FW-1:0]        l_a_q, l_b_q, l_s_q;
	logic                 l_neg_q, l_zero_q;
	logic signed [DW-1:0] l_ya_q, va_q, vb_q, res_q;
	logic                 fnd_q;
	logic                 sq_start_q, div_start_q;
	logic                 out_valid_q, found_q;
	logic signed [DW-1:0] interp_q;

	logic [DW-1:0]        rad_rd, alt_rd, val_rd;
	logic                 sq_done, div_done;
	logic [DW-1:0]        sq_root;
	logic [PW-1:0]        div_quot;
	logic                 ram_we;
	logic                 accept;

	logic [DW-1:0]        op_p, op_pa, op_pb;
	logic signed [DW-1:0] op_ya, op_yb;
	logic [FW-1:0]        span, dp, dy;
	logic [MW-1:0]        mag;
	logic signed [SW-1:0] acc;
	logic signed [DW-1:0] lerp_out;
	logic                 hit_a, hit_b;
	logic [AW-1:0]        idx_hit;
	logic [AW-1:0]        faddr;

	function automatic logic [FW-1:0] abs_f(input logic [FW-1:0] v);
		return v[FW-1] ? FW'(-v) : v;
	endfunction

	function automatic logic [DW-1:0] abs32(input logic [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : v;
	endfunction

	function automatic logic col_hit(input logic [DW-1:0] col, input logic [DW-1:0] cur_r,
			input logic [DW-1:0] prv_r, input logic [DW-1:0] cur_a,
			input logic [DW-1:0] prv_a, input logic [DW-1:0] alt);
		logic strict;
		strict = (cur_a < alt && prv_a > alt) || (cur_a > alt && prv_a < alt);
		return (cur_r == col) && ((alt == '0) || (prv_r == col && strict));
	endfunction

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign ram_we = accept && !req_type && ({22'd0, cell_index} < CELL_COUNT);

	cgi_ram #(.WIDTH(DW), .DEPTH(CELL_COUNT)) u_rad_ram (
		.clk(clk), .we(ram_we), .waddr(AW'(cell_index)), .wdata(cell_radius),
		.raddr(rd_addr_q), .rdata(rad_rd)
	);

	cgi_ram #(.WIDTH(DW), .DEPTH(CELL_COUNT)) u_alt_ram (
		.clk(clk), .we(ram_we), .waddr(AW'(cell_index)), .wdata(cell_altitude),
		.raddr(rd_addr_q), .rdata(alt_rd)
	);

	cgi_ram #(.WIDTH(DW), .DEPTH(CELL_COUNT)) u_val_ram (
		.clk(clk), .we(ram_we), .waddr(AW'(cell_index)), .wdata(cell_value),
		.raddr(rd_addr_q), .rdata(val_rd)
	);

	cgi_sqrt #(.ROOT_W(cgi_pkg::ROOT_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start_q), .radicand(sum_q),
		.done(sq_done), .root(sq_root)
	);

	cgi_div #(.NUM_W(PW), .DEN_W(FW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .num(mul_p_q), .den(l_s_q),
		.done(div_done), .quot(div_quot)
	);

	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = {1'b0, mx_q};
				mul_b = {1'b0, mx_q};
			end
			ST_SQY: begin
				mul_a = {1'b0, my_q};
				mul_b = {1'b0, my_q};
			end
			default: begin
				mul_a = l_a_q;
				mul_b = l_b_q;
			end
		endcase
	end

	always_comb begin
		case (lsel_q)
			2'd0: begin
				op_p = alt_q;
				op_pa = f_alt_q[0];
				op_pb = f_alt_q[1];
				op_ya = f_val_q[0];
				op_yb = f_val_q[1];
			end
			2'd1: begin
				op_p = alt_q;
				op_pa = f_alt_q[2];
				op_pb = f_alt_q[3];
				op_ya = f_val_q[2];
				op_yb = f_val_q[3];
			end
			default: begin
				op_p = rad_q;
				op_pa = rlo_q;
				op_pb = rhi_q;
				op_ya = va_q;
				op_yb = vb_q;
			end
		endcase
		span = {1'b0, op_pb} - {1'b0, op_pa};
		dp = {1'b0, op_p} - {1'b0, op_pa};
		dy = {op_yb[DW-1], op_yb} - {op_ya[DW-1], op_ya};
	end

	always_comb begin
		mag = (div_quot > PW'(cgi_pkg::SAT_LIMIT)) ? cgi_pkg::SAT_LIMIT : div_quot[MW-1:0];
		acc = l_neg_q ? SW'(l_ya_q) - SW'({1'b0, mag}) : SW'(l_ya_q) + SW'({1'b0, mag});
		if (l_zero_q) begin
			lerp_out = l_ya_q;
		end else if (acc > SW'(32'sh7fff_ffff)) begin
			lerp_out = 32'sh7fff_ffff;
		end else if (acc < -SW'(33'sh0_8000_0000)) begin
			lerp_out = 32'sh8000_0000;
		end else begin
			lerp_out = acc[DW-1:0];
		end
	end

	always_comb begin
		hit_a = !fa_q && col_hit(rlo_q, rad_rd, prev_rad_q, alt_rd, prev_alt_q, alt_q);
		hit_b = !fb_q && col_hit(rhi_q, rad_rd, prev_rad_q, alt_rd, prev_alt_q, alt_q);
		idx_hit = (alt_q == '0) ? rd_idx_s1 + 1'b1 : rd_idx_s1;
		case (fcnt_q[1:0])
			2'd0: faddr = za_q - 1'b1;
			2'd1: faddr = za_q;
			2'd2: faddr = zb_q - 1'b1;
			default: faddr = zb_q;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_addr_q <= '0;
			sq_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			fa_q <= 1'b0;
			fb_q <= 1'b0;
			fcnt_q <= '0;
			lsel_q <= '0;
		end else begin
			sq_start_q <= 1'b0;
			div_start_q <= 1'b0;
			rd_vld_s1 <= issue_q;
			rd_idx_s1 <= rd_addr_q;
			if (issue_q) begin
				if (rd_addr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && req_type) begin
						mx_q <= abs32(x_pos);
						my_q <= abs32(y_pos);
						alt_q <= abs32(z_pos);
						state_q <= ST_SQX;
					end
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					sum_q <= mul_p_q[2*DW-1:0];
					state_q <= ST_SQS;
				end
				ST_SQS: begin
					sum_q <= sum_q + mul_p_q[2*DW-1:0];
					sq_start_q <= 1'b1;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_done) begin
						rad_q <= sq_root;
						rd_addr_q <= '0;
						issue_q <= 1'b1;
						rd_vld_s1 <= 1'b0;
						state_q <= ST_RSCAN;
					end
				end
				ST_RSCAN: begin
					if (rd_vld_s1) begin
						prev_rad_q <= rad_rd;
						if (rd_idx_s1 != '0 &&
								((rad_rd <= rad_q && prev_rad_q >= rad_q) ||
								(rad_rd >= rad_q && prev_rad_q <= rad_q))) begin
							rlo_q <= prev_rad_q;
							rhi_q <= rad_rd;
							rd_addr_q <= '0;
							issue_q <= 1'b1;
							rd_vld_s1 <= 1'b0;
							fa_q <= 1'b0;
							fb_q <= 1'b0;
							state_q <= ST_VSCAN;
						end else if (rd_idx_s1 == LAST_IDX) begin
							res_q <= '0;
							fnd_q <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_VSCAN: begin
					if (rd_vld_s1) begin
						prev_rad_q <= rad_rd;
						prev_alt_q <= alt_rd;
						if (rd_idx_s1 != '0) begin
							if (hit_a) begin
								fa_q <= 1'b1;
								za_q <= idx_hit;
							end
							if (hit_b) begin
								fb_q <= 1'b1;
								zb_q <= idx_hit;
							end
							if ((fa_q || hit_a) && (fb_q || hit_b)) begin
								issue_q <= 1'b0;
								fcnt_q <= '0;
								state_q <= ST_FETCH;
							end else if (rd_idx_s1 == LAST_IDX) begin
								res_q <= '0;
								fnd_q <= 1'b0;
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_FETCH: begin
					if (fcnt_q < 3'd4) begin
						rd_addr_q <= faddr;
					end
					if (fcnt_q >= 3'd2) begin
						f_alt_q[2'(fcnt_q - 3'd2)] <= alt_rd;
						f_val_q[2'(fcnt_q - 3'd2)] <= val_rd;
					end
					if (fcnt_q == 3'd5) begin
						lsel_q <= '0;
						state_q <= ST_LSET;
					end
					fcnt_q <= fcnt_q + 1'b1;
				end
				ST_LSET: begin
					l_a_q <= abs_f(dp);
					l_b_q <= abs_f(dy);
					l_s_q <= abs_f(span);
					l_neg_q <= (dp[FW-1] ^ dy[FW-1]) ^ span[FW-1];
					l_zero_q <= (span == '0);
					l_ya_q <= op_ya;
					state_q <= ST_LMUL;
				end
				ST_LMUL, ST_LDIV: begin
					if (state_q == ST_LMUL && !l_zero_q) begin
						div_start_q <= 1'b1;
						state_q <= ST_LDIV;
					end else if (state_q == ST_LMUL || div_done) begin
						case (lsel_q)
							2'd0: begin
								va_q <= lerp_out;
								lsel_q <= 2'd1;
								state_q <= ST_LSET;
							end
							2'd1: begin
								vb_q <= lerp_out;
								lsel_q <= 2'd2;
								state_q <= ST_LSET;
							end
							default: begin
								res_q <= lerp_out;
								fnd_q <= 1'b1;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						interp_q <= res_q;
						found_q <= fnd_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign interp_value = interp_q;
	assign found = found_q;

	a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_SQRT)
		else $error("square root finished outside its state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_LDIV)
		else $error("division finished outside its state");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> interp_value == '0)
		else $error("missing bracket gave a nonzero value");

	a_no_scan_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !rd_vld_s1)
		else $error("table scan active while idle");

endmodule

@@ rtl/cgi_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Used for the grid tables; depends on cgi_pkg for the default widths.
module cgi_ram #(
	parameter int WIDTH = cgi_pkg::DATA_W,
	parameter int DEPTH = cgi_pkg::CELL_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cgi_sqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on cgi_pkg for the root width.
module cgi_sqrt #(
	parameter int ROOT_W = cgi_pkg::ROOT_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);

	localparam int REM_W = ROOT_W + 4;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [2*ROOT_W-1:0] rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [REM_W-1:0]    shifted;
	logic [REM_W-1:0]    trial;
	logic                take;

	always_comb begin
		shifted = {rem_q[REM_W-3:0], rad_q[2*ROOT_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		take = shifted >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				rad_q <= radicand;
				rem_q <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q <= rad_q << 2;
				rem_q <= take ? shifted - trial : shifted;
				root_q <= {root_q[ROOT_W-2:0], take};
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/cgi_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cgi_pkg for the default widths.
module cgi_div #(
	parameter int NUM_W = cgi_pkg::PROD_W,
	parameter int DEN_W = cgi_pkg::DIFF_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             take;

	always_comb begin
		shifted = {rem_q, num_q[NUM_W-1]};
		diff = shifted - {1'b0, den_q};
		take = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
			end else if (busy_q) begin
				rem_q <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], take};
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule
